@@ rtl/core/stt_pkg.sv @@
// ----------------------------------------------------------------------------
// stt_pkg - shared types and constants of the sorted tag table
// Command codes, datapath operations, status bundle and the key mask decoder.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int unsigned TAG_W    = 48;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned IDX_IN_W = 4;
  localparam int unsigned LEN_W    = 3;
  localparam int unsigned CNT_IN_W = 5;

  // request command codes
  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SORT   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  // operation the controller asks of the datapath in the current cycle
  typedef enum logic [3:0] {
    DP_IDLE,
    DP_LOAD,
    DP_WRITE,
    DP_PASS_START,
    DP_CARRY,
    DP_CMP,
    DP_PASS_END,
    DP_PROBE,
    DP_CHECK
  } stt_op_t;

  // datapath status seen by the controller
  typedef struct packed {
    logic wr_ok;
    logic limit_zero;
    logic last_cmp;
    logic range_empty;
    logic hit;
  } stt_stat_t;

  // keep the leading key bytes; a length of 0 counts as 1, 7 as 6
  function automatic logic [TAG_W-1:0] key_mask(input logic [LEN_W-1:0] len);
    logic [TAG_W-1:0] m;
    unique case (len) inside
      3'd0, 3'd1: m = 48'hFF00_0000_0000;
      3'd2:       m = 48'hFFFF_0000_0000;
      3'd3:       m = 48'hFFFF_FF00_0000;
      3'd4:       m = 48'hFFFF_FFFF_0000;
      3'd5:       m = 48'hFFFF_FFFF_FF00;
      3'd6, 3'd7: m = 48'hFFFF_FFFF_FFFF;
      default:    m = 48'hFFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/core/stt_ram.sv @@
// ----------------------------------------------------------------------------
// stt_ram - generic single write, single read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module stt_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/stt_dpath.sv @@
// ----------------------------------------------------------------------------
// stt_dpath - datapath of the sorted tag table
// Holds the count register, request fields, sort and search counters and the
// tag RAM; carries out one operation per cycle as the controller commands.
// ----------------------------------------------------------------------------
module stt_dpath #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  stt_pkg::stt_op_t                    op,
  input  logic                                cfg_wr_en,
  input  logic [stt_pkg::CNT_IN_W-1:0]        cfg_wr_data,
  input  logic [stt_pkg::IDX_IN_W-1:0]        in_entry_index,
  input  logic [stt_pkg::TAG_W-1:0]           in_tag_bytes,
  input  logic [stt_pkg::LEN_W-1:0]           in_key_length,
  output stt_pkg::stt_stat_t                  stat
);

  import stt_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CW    = $clog2(MAX_ENTRIES + 1);

  logic [CNT_IN_W-1:0] ent_cnt_r;
  logic [TAG_W-1:0]    tag_r;
  logic [TAG_W-1:0]    mask_r;
  logic [IDX_W-1:0]    idx_r;
  logic                wr_ok_r;
  logic [CW-1:0]       limit_r;
  logic [CW-1:0]       j_r;
  logic [CW-1:0]       lo_r;
  logic [CW-1:0]       hi_r;
  logic [IDX_W-1:0]    mid_r;
  logic [TAG_W-1:0]    carry_r;

  logic [CW-1:0]       n_w;
  logic [CW-1:0]       jp1;
  logic [CW-1:0]       jp2;
  logic [CW-1:0]       span;
  logic [CW-1:0]       mid_w;
  logic [TAG_W-1:0]    rd_data;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [TAG_W-1:0]    ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  logic                swap;
  logic                less;

  // effective count: clamp to the table size
  assign n_w = (32'(ent_cnt_r) > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(ent_cnt_r);

  assign jp1   = j_r + CW'(1);
  assign jp2   = j_r + CW'(2);
  assign span  = hi_r - lo_r - CW'(1);
  assign mid_w = lo_r + (span >> 1);

  assign swap = carry_r > rd_data;
  assign less = (rd_data & mask_r) < (tag_r & mask_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_cnt_r <= '0;
    end else if (cfg_wr_en) begin
      ent_cnt_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      DP_LOAD: begin
        tag_r   <= in_tag_bytes;
        mask_r  <= key_mask(in_key_length);
        idx_r   <= IDX_W'(in_entry_index);
        wr_ok_r <= 32'(in_entry_index) < 32'(n_w);
        limit_r <= (n_w == '0) ? '0 : n_w - CW'(1);
        lo_r    <= '0;
        hi_r    <= n_w;
      end
      DP_PASS_START: begin
        j_r <= '0;
      end
      DP_CARRY: begin
        carry_r <= rd_data;
      end
      DP_CMP: begin
        // keep the larger entry moving up
        if (!swap) begin
          carry_r <= rd_data;
        end
        j_r <= jp1;
      end
      DP_PASS_END: begin
        limit_r <= limit_r - CW'(1);
      end
      DP_PROBE: begin
        mid_r <= mid_w[IDX_W-1:0];
      end
      DP_CHECK: begin
        if (less) begin
          lo_r <= CW'(mid_r) + CW'(1);
        end else begin
          hi_r <= CW'(mid_r);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = tag_r;
    ram_raddr = '0;
    case (op)
      DP_WRITE: begin
        ram_we = wr_ok_r;
      end
      DP_CARRY: begin
        ram_raddr = jp1[IDX_W-1:0];
      end
      DP_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = j_r[IDX_W-1:0];
        ram_wdata = swap ? rd_data : carry_r;
        ram_raddr = jp2[IDX_W-1:0];
      end
      DP_PASS_END: begin
        ram_we    = 1'b1;
        ram_waddr = limit_r[IDX_W-1:0];
        ram_wdata = carry_r;
      end
      DP_PROBE: begin
        ram_raddr = mid_w[IDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  stt_ram #(
    .WIDTH (TAG_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  assign stat.wr_ok       = wr_ok_r;
  assign stat.limit_zero  = (limit_r == '0);
  assign stat.last_cmp    = (jp1 == limit_r);
  assign stat.range_empty = !(lo_r < hi_r);
  assign stat.hit         = ((rd_data ^ tag_r) & mask_r) == '0;

endmodule

@@ rtl/core/stt_ctrl.sv @@
// ----------------------------------------------------------------------------
// stt_ctrl - controller of the sorted tag table
// Sequences write, bubble sort and binary search; drives the result strobe.
// ----------------------------------------------------------------------------
module stt_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [stt_pkg::CMD_W-1:0]   in_command,
  input  stt_pkg::stt_stat_t          stat,
  output stt_pkg::stt_op_t            op,
  output logic                        busy,
  output logic                        out_strobe,
  output logic                        out_found,
  output logic                        out_error
);

  import stt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRITE,
    S_SORT_TEST,
    S_SORT_CARRY,
    S_SORT_CMP,
    S_SORT_END,
    S_SRCH_TEST,
    S_SRCH_CHECK
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   strobe_r, strobe_nxt;
  logic   found_r, found_nxt;
  logic   error_r, error_nxt;

  always_comb begin
    state_nxt  = state_r;
    op         = DP_IDLE;
    strobe_nxt = 1'b0;
    found_nxt  = 1'b0;
    error_nxt  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op = DP_LOAD;
          unique case (in_command)
            CMD_WRITE:  state_nxt = S_WRITE;
            CMD_SORT:   state_nxt = S_SORT_TEST;
            CMD_SEARCH: state_nxt = S_SRCH_TEST;
            CMD_NONE:   strobe_nxt = 1'b1;
            default:    strobe_nxt = 1'b1;
          endcase
        end
      end
      S_WRITE: begin
        op         = DP_WRITE;
        strobe_nxt = 1'b1;
        error_nxt  = !stat.wr_ok;
        state_nxt  = S_IDLE;
      end
      S_SORT_TEST: begin
        if (stat.limit_zero) begin
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          op        = DP_PASS_START;
          state_nxt = S_SORT_CARRY;
        end
      end
      S_SORT_CARRY: begin
        op        = DP_CARRY;
        state_nxt = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        op = DP_CMP;
        if (stat.last_cmp) begin
          state_nxt = S_SORT_END;
        end
      end
      S_SORT_END: begin
        op        = DP_PASS_END;
        state_nxt = S_SORT_TEST;
      end
      S_SRCH_TEST: begin
        if (stat.range_empty) begin
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          op        = DP_PROBE;
          state_nxt = S_SRCH_CHECK;
        end
      end
      S_SRCH_CHECK: begin
        op = DP_CHECK;
        if (stat.hit) begin
          strobe_nxt = 1'b1;
          found_nxt  = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_SRCH_TEST;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      busy_r   <= 1'b0;
      strobe_r <= 1'b0;
      found_r  <= 1'b0;
      error_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      busy_r   <= busy_nxt;
      strobe_r <= strobe_nxt;
      found_r  <= found_nxt;
      error_r  <= error_nxt;
    end
  end

  assign busy       = busy_r;
  assign out_strobe = strobe_r;
  assign out_found  = found_r;
  assign out_error  = error_r;

endmodule

@@ rtl/core/sorted_tag_table_lookup_core.sv @@
// ----------------------------------------------------------------------------
// sorted_tag_table_lookup_core - sorted table of 48-bit tags with lookup
// Write, bubble sort and prefix binary search over a small tag table.
// ----------------------------------------------------------------------------
// A request is taken on a clock edge with start high and busy low. Every
// request gives exactly one result: out_strobe is high for one cycle with
// out_found and out_error valid, and the receiver must take it there and
// then. A search makes at most log2(n) + 1 probes, and a sort of n used
// entries makes one pass of L compares for each L from n-1 down to 1. The
// tag RAM has a single read port: each probe needs a registered read
// before its compare, and each bubble pass streams one compare per cycle
// after a lead-in through the pass start and carry states. Busy falls in
// the cycle the result appears, so the next request may go in alongside
// it. The user must write the count register through cfg_wr_en and
// cfg_wr_data only while idle; the block itself does not enforce this.
// Count values above the table size act as the table size.
// Entries must be written before a sort or search touches them.
// ----------------------------------------------------------------------------
module sorted_tag_table_lookup_core #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [stt_pkg::CMD_W-1:0]     in_command,
  input  logic [stt_pkg::IDX_IN_W-1:0]  in_entry_index,
  input  logic [stt_pkg::TAG_W-1:0]     in_tag_bytes,
  input  logic [stt_pkg::LEN_W-1:0]     in_key_length,
  output logic                          out_strobe,
  output logic                          out_found,
  output logic                          out_error,
  input  logic                          cfg_wr_en,
  input  logic [stt_pkg::CNT_IN_W-1:0]  cfg_wr_data
);

  import stt_pkg::*;

  // controller to datapath: one operation per cycle
  stt_op_t   op;
  // datapath to controller: write permission, loop ends, search hit
  stt_stat_t stat;
  // start qualified by busy
  logic      req_take;

  assign req_take = start & ~busy;

  stt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (req_take),
    .in_command (in_command),
    .stat       (stat),
    .op         (op),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_found  (out_found),
    .out_error  (out_error)
  );

  stt_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .op             (op),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_entry_index (in_entry_index),
    .in_tag_bytes   (in_tag_bytes),
    .in_key_length  (in_key_length),
    .stat           (stat)
  );

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb - self-checking bench for sorted_tag_table_lookup_core
// Drives write, sort, search and unused requests through the start/busy port,
// keeps a shadow tag table that predicts every result, and checks each
// strobed result against the oldest outstanding prediction. The table-size
// register is moved through empty, small, full and oversized settings.
// ----------------------------------------------------------------------------
module tb;
  import stt_pkg::*;

  localparam int unsigned TABLE_DEPTH    = 16;
  localparam int unsigned TAG_BYTE_COUNT = 6;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned TAIL_CYCLES    = 8;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PRINT_CAP      = 40;

  typedef struct packed {
    logic found;
    logic error;
  } tag_result_t;

  // DUT ports, all inputs at known values from time zero
  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 start          = 1'b0;
  logic                 busy;
  logic [CMD_W-1:0]     in_command     = CMD_NONE;
  logic [IDX_IN_W-1:0]  in_entry_index = '0;
  logic [TAG_W-1:0]     in_tag_bytes   = '0;
  logic [LEN_W-1:0]     in_key_length  = '0;
  logic                 out_strobe;
  logic                 out_found;
  logic                 out_error;
  logic                 cfg_wr_en      = 1'b0;
  logic [CNT_IN_W-1:0]  cfg_wr_data    = '0;

  // shadow copy of the block: table contents, which rows hold data, count
  logic [TAG_W-1:0]     shadow_tags [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] tag_valid  = '0;
  logic [CNT_IN_W-1:0]  entry_count_q = '0;

  tag_result_t          pending_results [$];
  int unsigned          mismatch_count = 0;
  int unsigned          idle_cycles    = 0;
  int unsigned          gap_percent    = 0;

  sorted_tag_table_lookup_core #(
    .MAX_ENTRIES (TABLE_DEPTH)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_entry_index (in_entry_index),
    .in_tag_bytes   (in_tag_bytes),
    .in_key_length  (in_key_length),
    .out_strobe     (out_strobe),
    .out_found      (out_found),
    .out_error      (out_error),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Shadow table predictor
  // --------------------------------------------------------------------------

  // clamp the count register to the table depth
  function automatic int unsigned used_count();
    return (entry_count_q > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count_q);
  endfunction

  // map a key length onto 1..6 compared bytes
  function automatic int unsigned compared_bytes(input logic [LEN_W-1:0] len);
    if (len == 0)
      return 1;
    if (len > TAG_BYTE_COUNT)
      return TAG_BYTE_COUNT;
    return int'(len);
  endfunction

  // halving search over the used rows, comparing the leading bytes only
  function automatic logic prefix_search(input int unsigned n, input logic [TAG_W-1:0] key,
                                         input logic [LEN_W-1:0] len);
    int               lo;
    int               hi;
    int               mid;
    int unsigned      shift;
    logic [TAG_W-1:0] want;
    logic [TAG_W-1:0] have;
    shift = 8 * (TAG_BYTE_COUNT - compared_bytes(len));
    want  = key >> shift;
    lo    = 0;
    hi    = int'(n) - 1;
    while (lo <= hi) begin
      mid  = lo + (hi - lo) / 2;
      have = shadow_tags[mid] >> shift;
      if (have == want)
        return 1'b1;
      if (have < want)
        lo = mid + 1;
      else
        hi = mid - 1;
    end
    return 1'b0;
  endfunction

  // ascending bubble sort of the used rows, full 48-bit compare
  function automatic void bubble_sort_tags(input int unsigned n);
    logic [TAG_W-1:0] swap;
    for (int i = 0; i < int'(n) - 1; i++) begin
      for (int j = 0; j < int'(n) - i - 1; j++) begin
        if (shadow_tags[j] > shadow_tags[j+1]) begin
          swap             = shadow_tags[j];
          shadow_tags[j]   = shadow_tags[j+1];
          shadow_tags[j+1] = swap;
        end
      end
    end
  endfunction

  // apply one accepted request to the shadow table and return its result
  function automatic tag_result_t predict_lookup(input logic [CMD_W-1:0] cmd,
                                                 input logic [IDX_IN_W-1:0] idx,
                                                 input logic [TAG_W-1:0] tag,
                                                 input logic [LEN_W-1:0] len);
    tag_result_t res;
    int unsigned n;
    res = '0;
    n   = used_count();
    case (cmd)
      CMD_WRITE: begin
        if (idx < n) begin
          shadow_tags[idx] = tag;
          tag_valid[idx]   = 1'b1;
        end else begin
          res.error = 1'b1;
        end
      end
      CMD_SORT:   bubble_sort_tags(n);
      CMD_SEARCH: res.found = prefix_search(n, tag, len);
      default: ;
    endcase
    return res;
  endfunction

  // sort and search may only touch rows that have been written
  function automatic bit table_ready();
    for (int i = 0; i < int'(used_count()); i++) begin
      if (!tag_valid[i])
        return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int unsigned first_unwritten();
    for (int i = 0; i < int'(TABLE_DEPTH); i++) begin
      if (!tag_valid[i])
        return i;
    end
    return 0;
  endfunction

  // --------------------------------------------------------------------------
  // Random data
  // --------------------------------------------------------------------------

  function automatic logic [TAG_W-1:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TAG_W-1:0];
  endfunction

  // mix of fully random tags, corner bytes and tags sharing a prefix, so that
  // short key lengths find several candidates
  function automatic logic [TAG_W-1:0] random_tag();
    logic [TAG_W-1:0] t;
    logic [7:0]       corner [4];
    corner = '{8'h00, 8'hFF, 8'h80, 8'h01};
    t = rand48();
    case ($urandom_range(0, 3))
      1: begin
        for (int b = 0; b < int'(TAG_BYTE_COUNT); b++)
          t[8*b +: 8] = corner[$urandom_range(0, 3)];
      end
      2: t[47:32] = 16'hA5C3;
      3: t[47:24] = {16'h0F0F, 8'($urandom_range(0, 3))};
      default: ;
    endcase
    return t;
  endfunction

  // key matching row j in its compared bytes, junk below; now and then one
  // compared bit is flipped to give a near miss
  function automatic logic [TAG_W-1:0] key_near_entry(input int unsigned j,
                                                      input logic [LEN_W-1:0] len);
    int unsigned      nbytes;
    int unsigned      flip;
    logic [TAG_W-1:0] keep;
    logic [TAG_W-1:0] key;
    nbytes = compared_bytes(len);
    keep   = {TAG_W{1'b1}} << (8 * (TAG_BYTE_COUNT - nbytes));
    key    = (shadow_tags[j] & keep) | (rand48() & ~keep);
    if ($urandom_range(0, 4) == 0) begin
      flip      = TAG_W - 1 - $urandom_range(0, 8 * nbytes - 1);
      key[flip] = ~key[flip];
    end
    return key;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver and idle control
  // --------------------------------------------------------------------------

  // Offer one request and hold it until taken. Start stays high afterwards so
  // that back-to-back requests never lower and raise it in one step; drop it
  // only for an idle burst or a drain.
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [IDX_IN_W-1:0] idx,
                              input logic [TAG_W-1:0] tag, input logic [LEN_W-1:0] len);
    tag_result_t want;
    if (gap_percent != 0 && $urandom_range(1, 100) <= gap_percent) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    start          <= 1'b1;
    in_command     <= cmd;
    in_entry_index <= idx;
    in_tag_bytes   <= tag;
    in_key_length  <= len;
    do
      @(posedge clk);
    while (busy !== 1'b0);
    want = predict_lookup(cmd, idx, tag, len);
    pending_results.push_back(want);
  endtask

  // drop start, wait for every outstanding result, then let the block settle
  task automatic wait_all_results();
    start <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // the count register is only written with the block idle
  task automatic set_entry_count(input logic [CNT_IN_W-1:0] value);
    wait_all_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    entry_count_q  = value;
  endtask

  // one random request; fill unwritten rows first so sort and search go deep
  task automatic send_random_request();
    int unsigned        pick;
    int unsigned        n;
    logic [LEN_W-1:0]   len;
    logic [IDX_IN_W-1:0] idx;
    pick = $urandom_range(0, 99);
    n    = used_count();
    len  = LEN_W'($urandom_range(0, 7));
    idx  = IDX_IN_W'($urandom_range(0, 15));
    if (!table_ready()) begin
      send_request(CMD_WRITE, IDX_IN_W'(first_unwritten()), random_tag(), len);
    end else if (pick < 28) begin
      if (n != 0 && pick < 16)
        idx = IDX_IN_W'($urandom_range(0, n - 1));
      send_request(CMD_WRITE, idx, random_tag(), len);
    end else if (pick < 38) begin
      send_request(CMD_SORT, idx, random_tag(), len);
    end else if (pick < 88 && n != 0) begin
      send_request(CMD_SEARCH, idx, key_near_entry($urandom_range(0, n - 1), len), len);
    end else if (pick < 94) begin
      send_request(CMD_SEARCH, idx, random_tag(), len);
    end else begin
      send_request(CMD_NONE, idx, random_tag(), len);
    end
  endtask

  task automatic run_phase(input logic [CNT_IN_W-1:0] count, input int unsigned items,
                           input int unsigned gap_pct);
    set_entry_count(count);
    gap_percent = gap_pct;
    repeat (items) send_random_request();
  endtask

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP)
      $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // A result is taken at the edge ending its strobe cycle. A new request may
  // be taken at the same edge, but its prediction goes to the back of the
  // queue, so the front is always the older one.
  always @(posedge clk) begin : result_check
    tag_result_t exp_r;
    if (rst_n) begin
      if (out_strobe === 1'b1) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result strobed with no request outstanding");
        end else begin
          exp_r = pending_results.pop_front();
          if (out_found !== exp_r.found)
            report_mismatch($sformatf("found %b, expected %b", out_found, exp_r.found));
          if (out_error !== exp_r.error)
            report_mismatch($sformatf("error %b, expected %b", out_error, exp_r.error));
        end
      end else if (out_strobe !== 1'b0) begin
        report_mismatch("result strobe unknown");
      end
    end
  end

  // end the run if neither a request nor a result moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_strobe === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // empty table: writes are refused, sort and search touch nothing
  task automatic test_empty_table();
    set_entry_count(5'd0);
    send_request(CMD_WRITE, 4'd0, 48'h0000_0000_0000, 3'd6);
    send_request(CMD_WRITE, 4'd15, 48'hFFFF_FFFF_FFFF, 3'd1);
    send_request(CMD_SORT, 4'd0, 48'h0, 3'd0);
    send_request(CMD_SEARCH, 4'd0, 48'h0000_0000_0000, 3'd6);
    send_request(CMD_NONE, 4'd15, 48'hFFFF_FFFF_FFFF, 3'd7);
  endtask

  // five rows with extreme tags: boundary write, search before and after the
  // sort, every key length including the clamped ones, hits and misses
  task automatic test_small_table();
    set_entry_count(5'd5);
    send_request(CMD_WRITE, 4'd0, 48'hFFFF_FFFF_FFFF, 3'd0);
    send_request(CMD_WRITE, 4'd1, 48'h0000_0000_0000, 3'd7);
    send_request(CMD_WRITE, 4'd2, 48'h1234_5678_9ABC, 3'd3);
    send_request(CMD_WRITE, 4'd3, 48'h1234_0000_0000, 3'd2);
    send_request(CMD_WRITE, 4'd4, 48'h8000_0000_0001, 3'd5);
    send_request(CMD_WRITE, 4'd5, 48'h5555_5555_5555, 3'd4);
    // unsorted table: probe order misses a present tag
    send_request(CMD_SEARCH, 4'd0, 48'h0000_0000_0000, 3'd6);
    send_request(CMD_SORT, 4'd9, 48'hAAAA_AAAA_AAAA, 3'd1);
    send_request(CMD_SEARCH, 4'd0, 48'h0000_0000_0000, 3'd6);
    send_request(CMD_SEARCH, 4'd0, 48'h1234_FFFF_FFFF, 3'd2);
    send_request(CMD_SEARCH, 4'd0, 48'h12FF_FFFF_FFFF, 3'd0);
    send_request(CMD_SEARCH, 4'd0, 48'hFFFF_FFFF_FFFF, 3'd7);
    send_request(CMD_SEARCH, 4'd0, 48'h1234_5678_9ABD, 3'd6);
    send_request(CMD_SEARCH, 4'd0, 48'h1234_5678_9AFF, 3'd5);
    send_request(CMD_SEARCH, 4'd0, 48'h8000_0012_3456, 3'd3);
    send_request(CMD_SEARCH, 4'd0, 48'h7FFF_FFFF_FFFF, 3'd1);
    send_request(CMD_SEARCH, 4'd0, 48'h1234_0000_0001, 3'd4);
    send_request(CMD_NONE, 4'd3, 48'h1234_5678_9ABC, 3'd6);
  endtask

  // phases over many counts, with idle bursts of varying density; every
  // phase starts with a full drain before the count changes
  task automatic test_random_traffic();
    logic [CNT_IN_W-1:0] count;
    for (int p = 0; p < 12; p++) begin
      case (p)
        0:       count = 5'd16;
        1:       count = 5'd31;
        2:       count = 5'd1;
        3:       count = 5'd0;
        4:       count = 5'd2;
        5:       count = 5'd17;
        default: count = CNT_IN_W'($urandom_range(0, 31));
      endcase
      run_phase(count, 60, (p % 4 == 3) ? 0 : $urandom_range(5, 60));
    end
  endtask

  // closing stretch with no idling at all
  task automatic test_streaming();
    run_phase(5'd16, 60, 0);
    run_phase(CNT_IN_W'($urandom_range(3, 16)), 60, 0);
  endtask

  initial begin
    // hold reset low from time zero, then release
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_small_table();
    test_random_traffic();
    test_streaming();
    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/stt_pkg.sv
rtl/core/stt_ram.sv
rtl/core/stt_dpath.sv
rtl/core/stt_ctrl.sv
rtl/core/sorted_tag_table_lookup_core.sv
test/tb.sv
